/* rtl/sha256_pkg.sv */
package sha256_pkg;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam logic [7:0]  PadByte    = 8'h80;

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* rtl/sha256_round.sv */
// One SHA-256 round plus one schedule extension step; shared over all 64 rounds.
module sha256_round (
   input  logic [31:0] state_in [8],
   input  logic [31:0] w_in,
   input  logic [31:0] k_in,
   input  logic [31:0] w16,
   input  logic [31:0] w15,
   input  logic [31:0] w7,
   input  logic [31:0] w2,
   output logic [31:0] state_out [8],
   output logic [31:0] w_ext
);
   import sha256_pkg::*;

   logic [31:0] a, e, s0, s1, ch, maj, t1, t2, ws0, ws1;

   always_comb begin
      a   = state_in[0];
      e   = state_in[4];
      s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      ch  = (e & state_in[5]) ^ (~e & state_in[6]);
      t1  = state_in[7] + s1 + ch + k_in + w_in;
      s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      maj = (a & state_in[1]) ^ (a & state_in[2]) ^ (state_in[1] & state_in[2]);
      t2  = s0 + maj;
      state_out[7] = state_in[6];
      state_out[6] = state_in[5];
      state_out[5] = state_in[4];
      state_out[4] = state_in[3] + t1;
      state_out[3] = state_in[2];
      state_out[2] = state_in[1];
      state_out[1] = state_in[0];
      state_out[0] = t1 + t2;
      ws0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      ws1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      w_ext = w16 + w7 + ws0 + ws1;
   end

endmodule

/* rtl/sha256_stream_hasher_top.sv */
// channel | dir | handshake            | payload
// req_    | in  | req_valid/req_ready  | req_payload (operation, data_byte)
// rsp_    | out | rsp_valid/rsp_ready  | rsp_payload (digest_word, word_index, last_word)
//
// The 64th byte of a block holds req_ready low through load, 64 rounds in the
// shared round unit, and fold.
// A finish item fills the block one byte a cycle, then loads and compresses it;
// a pad byte at position 56 or later costs a second block of zeros and the
// length. Then 8 result items, one per accepted cycle.
// Synchronous active-high reset loads the initial hash and clears counts.
// req_ready is low while padding, compressing or emitting; rsp stalls hold the word.
module sha256_stream_hasher_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sha256_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sha256_pkg::rsp_payload_type rsp_payload
);
   import sha256_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [31:0] hash_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] w_ff [16];
   logic [6:0]  fill_ff;
   logic [60:0] count_ff;
   logic [5:0]  round_ff;
   logic        finishing_ff;
   logic        extra_ff;
   logic [2:0]  emit_ff;

   logic [31:0] round_out [8];
   logic [31:0] w_ext, w_cur;
   logic [63:0] bits;

   assign w_cur = (round_ff < 6'd16) ? w_ff[round_ff[3:0]] : w_ext;
   assign bits  = {count_ff, 3'b000};

   sha256_round u_round (
      .state_in (work_ff),
      .w_in     (w_cur),
      .k_in     (ROUND_K[round_ff]),
      .w16      (w_ff[round_ff[3:0]]),
      .w15      (w_ff[4'(round_ff[3:0] + 4'd1)]),
      .w7       (w_ff[4'(round_ff[3:0] + 4'd9)]),
      .w2       (w_ff[4'(round_ff[3:0] + 4'd14)]),
      .state_out(round_out),
      .w_ext    (w_ext)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_payload.digest_word = hash_ff[emit_ff];
   assign rsp_payload.word_index  = emit_ff;
   assign rsp_payload.last_word   = (emit_ff == 3'd7);

   // message bytes go straight into the schedule window, big-endian per word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         round_ff     <= '0;
         finishing_ff <= 1'b0;
         extra_ff     <= 1'b0;
         emit_ff      <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= START_HASH[i];
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <=
                     (req_payload.operation == OP_FINISH) ? PadByte : req_payload.data_byte;
                  fill_ff <= fill_ff + 7'd1;
                  if (req_payload.operation == OP_ABSORB) begin
                     count_ff <= count_ff + 61'd1;
                     if (fill_ff == 7'(BlockBytes - 1)) state_ff <= ST_LOAD;
                  end else begin
                     finishing_ff <= 1'b1;
                     extra_ff     <= (fill_ff >= 7'(LenPos));
                     state_ff     <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               // zero fill one byte a cycle; length goes in at LenPos unless
               // this is the block before the last one, which holds only zeros after the pad
               if (fill_ff == 7'(BlockBytes)) begin
                  state_ff <= ST_LOAD;
               end else begin
                  if (fill_ff < 7'(LenPos) || extra_ff)
                     w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= 8'h00;
                  else
                     w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <=
                        bits[{~fill_ff[2:0], 3'b000} +: 8];
                  fill_ff <= fill_ff + 7'd1;
               end
            end
            ST_LOAD: begin
               for (int i = 0; i < 8; i++) work_ff[i] <= hash_ff[i];
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               for (int i = 0; i < 8; i++) work_ff[i] <= round_out[i];
               if (round_ff >= 6'd16) w_ff[round_ff[3:0]] <= w_ext;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
               fill_ff <= '0;
               if (!finishing_ff) begin
                  state_ff <= ST_IDLE;
               end else if (extra_ff) begin
                  extra_ff <= 1'b0;
                  state_ff <= ST_PAD;
               end else begin
                  emit_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     state_ff     <= ST_IDLE;
                     finishing_ff <= 1'b0;
                     count_ff     <= '0;
                     for (int i = 0; i < 8; i++) hash_ff[i] <= START_HASH[i];
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while emitting");
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_word |=> rsp_valid)
      else $error("digest burst broken");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_word |=> req_ready)
      else $error("not idle after digest");
   a_round_fold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && round_ff == 6'd63 |=> state_ff == ST_FOLD)
      else $error("round count slip");

endmodule

/* tb/tb.sv */
module tb;
   import sha256_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   sha256_stream_hasher_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   int unsigned block_fill;
   logic [60:0] byte_total;
   rsp_payload_type digest_queue [$];

   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   localparam int unsigned WatchdogLimit = 20000;

   function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_msg_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, w15, w2, t1, t2, e, a;
      for (int j = 0; j < 16; j++)
         w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
      for (int j = 0; j < 8; j++) v[j] = hash_state[j];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            w15 = w[(r - 15) & 15];
            w2  = w[(r - 2) & 15];
            wr = w[r & 15] + w[(r - 7) & 15]
                 + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                 + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
            w[r & 15] = wr;
         end
         e = v[4];
         a = v[0];
         t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
              + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[r] + wr;
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
              + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
      block_fill = 0;
   endtask

   task automatic restart_hash();
      for (int j = 0; j < 8; j++) hash_state[j] = START_HASH[j];
      block_fill = 0;
      byte_total = '0;
   endtask

   task automatic predict_digest(req_payload_type it);
      logic [63:0] bit_len;
      rsp_payload_type r;
      if (it.operation == OP_ABSORB) begin
         msg_block[block_fill] = it.data_byte;
         block_fill++;
         byte_total++;
         if (block_fill == BlockBytes) compress_msg_block();
      end else begin
         bit_len = {byte_total, 3'b000};
         msg_block[block_fill] = PadByte;
         block_fill++;
         if (block_fill > LenPos) begin
            while (block_fill < BlockBytes) begin
               msg_block[block_fill] = 8'h00;
               block_fill++;
            end
            compress_msg_block();
         end
         while (block_fill < LenPos) begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
         end
         for (int i = 0; i < 8; i++) msg_block[LenPos + i] = bit_len[63 - 8*i -: 8];
         compress_msg_block();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_state[i];
            r.word_index = 3'(i);
            r.last_word = (i == 7);
            digest_queue.push_back(r);
         end
         restart_hash();
      end
   endtask

   function automatic int unsigned random_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   bit gaps_on = 1'b1;

   // called at a falling edge; valid stays high into the next item when there is no gap
   task automatic send_item(logic op, logic [7:0] data);
      req_payload_type it;
      int unsigned gap;
      it.operation = op;
      it.data_byte = data;
      gap = gaps_on ? random_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_digest(it);
      @(negedge clock);
   endtask

   task automatic absorb(logic [7:0] data);
      send_item(OP_ABSORB, data);
   endtask

   task automatic finish_msg();
      send_item(OP_FINISH, 8'($urandom));
   endtask

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (!gaps_on) rsp_ready <= 1'b1;
      else rsp_ready <= (random_gap() == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            $error("unexpected digest item %h", rsp_payload);
            error_count++;
         end else begin
            rsp_payload_type x;
            x = digest_queue.pop_front();
            if (rsp_payload.digest_word !== x.digest_word) begin
               $error("digest_word exp %h got %h", x.digest_word, rsp_payload.digest_word);
               error_count++;
            end
            if (rsp_payload.word_index !== x.word_index) begin
               $error("word_index exp %0d got %0d", x.word_index, rsp_payload.word_index);
               error_count++;
            end
            if (rsp_payload.last_word !== x.last_word) begin
               $error("last_word exp %0d got %0d", x.last_word, rsp_payload.last_word);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic test_empty_message();
      finish_msg();
   endtask

   // extreme bytes lead a 55-byte message: pad and length just fit
   task automatic test_byte_extremes();
      absorb(8'h00); absorb(8'hff); absorb(8'h80); absorb(8'h7f);
      absorb(8'h55); absorb(8'haa); absorb(8'h01);
      repeat (48) absorb(8'($urandom));
      finish_msg();
   endtask

   // 56 bytes: extra block needed
   task automatic test_pad_boundaries();
      repeat (56) absorb(8'($urandom));
      finish_msg();
   endtask

   task automatic test_full_block();
      gaps_on = 1'b0;
      repeat (64) absorb(8'($urandom));
      finish_msg();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_messages();
      int unsigned sent = 0;
      int unsigned len;
      while (sent < 10) begin
         len = $urandom_range(0, 4);
         repeat (len) absorb(8'($urandom));
         finish_msg();
         sent += len + 1;
      end
   endtask

   initial begin
      restart_hash();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_byte_extremes();
      test_pad_boundaries();
      test_full_block();
      test_random_messages();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
